// ===== hw/rtl/assist_duty_curve_top_assert.svh =====
// Assertion macros shared by the assist duty curve RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSIST_DUTY_CURVE_TOP_ASSERT_SVH
`define ASSIST_DUTY_CURVE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ADC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ADC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/adc_pkg.sv =====
// Package for the assist duty curve block: widths, polynomial coefficients,
// register indexes, status codes and the structs passed between modules.
// No dependencies.
package adc_pkg;

  // Data path widths.
  localparam int AccW   = 56;  // Horner accumulator, signed Q32
  localparam int ProdW  = 64;  // product and sum width of the shared unit
  localparam int MulAW  = 30;  // signed operand A of the multiplier
  localparam int MulBW  = 17;  // signed operand B of the multiplier
  localparam int ChunkW = 28;  // accumulator split point for two-pass multiply
  localparam int RawW   = 36;  // signed raw duty after gain
  localparam int DutyW  = 16;
  localparam int StepW  = 3;

  // Horner runs over the five lower coefficients.
  localparam logic [StepW-1:0] LastStep = 3'd4;
  localparam logic [StepW-1:0] StepEnd  = 3'd5;

  // Rounding constants and shifts.
  localparam int HornerShift = 8;
  localparam int PolyShift   = 24;
  localparam int GainShift   = 12;

  // Register indexes of the configuration port.
  localparam int CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegGain       = 3'd0;
  localparam logic [CfgAddrW-1:0] RegOffset     = 3'd1;
  localparam logic [CfgAddrW-1:0] RegMinDuty    = 3'd2;
  localparam logic [CfgAddrW-1:0] RegMaxDuty    = 3'd3;
  localparam logic [CfgAddrW-1:0] RegWarnDuty   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegSmoothUp   = 3'd5;
  localparam logic [CfgAddrW-1:0] RegSmoothDown = 3'd6;

  // Result status codes.
  localparam logic [1:0] StatSmooth   = 2'd0;
  localparam logic [1:0] StatBelowMin = 2'd1;
  localparam logic [1:0] StatClamp    = 2'd2;
  localparam logic [1:0] StatWarnOff  = 2'd3;

  // Leading polynomial coefficient, signed Q32.
  localparam logic signed [AccW-1:0] CoefC5 = -56'sd1890;

  // Configuration registers.
  typedef struct packed {
    logic [15:0]        gain;
    logic signed [15:0] offset;
    logic [15:0]        min_duty;
    logic [15:0]        max_duty;
    logic [15:0]        warn_duty;
    logic [15:0]        smooth_up;
    logic [15:0]        smooth_down;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [1:0]       status;
  } result_t;

  // Request to the shared multiply-add unit.
  typedef struct packed {
    logic signed [MulAW-1:0] op_a;
    logic signed [MulBW-1:0] op_b;
    logic signed [ProdW-1:0] addend;
    logic                    shift_hi;
  } mac_req_t;

  // Lower polynomial coefficients in Horner order, signed Q32.
  function automatic logic signed [AccW-1:0] coef_lower(input logic [StepW-1:0] idx);
    logic signed [AccW-1:0] c;
    case (idx)
      3'd0:    c = -56'sd210453;
      3'd1:    c = 56'sd7043746;
      3'd2:    c = 56'sd72584947;
      3'd3:    c = 56'sd5074503860;
      default: c = 56'sd81226421502;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/adc_mac.sv =====
// Shared multiply-add unit of the assist duty curve block.
// Registered signed product, optionally shifted up by one chunk, plus addend.
// Depends on adc_pkg.
module adc_mac (
  input  logic                                 clk_i,
  input  adc_pkg::mac_req_t                    req_i,
  output logic signed [adc_pkg::ProdW-1:0]     res_o
);
  import adc_pkg::*;

  logic signed [MulAW+MulBW-1:0] prod;
  logic signed [ProdW-1:0]       prod_ext;
  logic signed [ProdW-1:0]       shifted;
  logic signed [ProdW-1:0]       res_d;
  logic signed [ProdW-1:0]       res_q;

  // Multiply, align the high chunk, then add.
  assign prod     = $signed(req_i.op_a) * $signed(req_i.op_b);
  assign prod_ext = ProdW'(prod);
  assign shifted  = req_i.shift_hi ? (prod_ext <<< ChunkW) : prod_ext;
  assign res_d    = shifted + $signed(req_i.addend);

  // Result register, payload only.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/adc_core.sv =====
// Sequencer and data path of the assist duty curve block: Horner evaluation,
// gain, range rules and smoothing, all on one shared multiply-add unit.
// Depends on adc_pkg, adc_mac and assist_duty_curve_top_assert.svh.
module adc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  adc_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [adc_pkg::DutyW-1:0]    in_speed_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output adc_pkg::result_t             res_o
);
  import adc_pkg::*;

  // Sequencer states.
  localparam logic [3:0] SIdle     = 4'd0;
  localparam logic [3:0] SMulLo    = 4'd1;
  localparam logic [3:0] SMulHi    = 4'd2;
  localparam logic [3:0] SAccum    = 4'd3;
  localparam logic [3:0] SPoly     = 4'd4;
  localparam logic [3:0] SGain     = 4'd5;
  localparam logic [3:0] SRange    = 4'd6;
  localparam logic [3:0] SBlend    = 4'd7;
  localparam logic [3:0] SBlendSum = 4'd8;
  localparam logic [3:0] SDone     = 4'd9;

  localparam logic signed [ProdW-1:0] HornerRound = ProdW'(2 ** (HornerShift - 1));
  localparam logic signed [ProdW-1:0] PolyRound   = ProdW'(2 ** (PolyShift - 1));
  localparam logic signed [ProdW-1:0] GainRound   = ProdW'(2 ** (GainShift - 1));

  logic [3:0]              state_q, state_d;
  logic [DutyW-1:0]        x_q, x_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [StepW-1:0]        step_q, step_d;
  logic signed [MulAW-1:0] s_q, s_d;
  logic [DutyW-1:0]        rawlo_q, rawlo_d;
  logic [DutyW-1:0]        duty_q, duty_d;
  logic [1:0]              status_q, status_d;
  logic [DutyW-1:0]        last_q, last_d;

  mac_req_t                mac_req;
  logic signed [ProdW-1:0] mac_res;
  logic signed [ProdW-1:0] poly_sum;
  logic signed [RawW-1:0]  raw;
  logic [DutyW-1:0]        weight;

  adc_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .res_o (mac_res)
  );

  // Values used by single states.
  assign poly_sum = ProdW'(acc_q) + (ProdW'($signed(cfg_i.offset)) <<< PolyShift) + PolyRound;
  assign raw      = RawW'(mac_res >>> GainShift);
  assign weight   = (rawlo_q > last_q) ? cfg_i.smooth_up : cfg_i.smooth_down;

  // Sequencer and operand selection for the shared unit.
  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    acc_d    = acc_q;
    step_d   = step_q;
    s_d      = s_q;
    rawlo_d  = rawlo_q;
    duty_d   = duty_q;
    status_d = status_q;
    last_d   = last_q;
    mac_req  = '0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          x_d     = in_speed_i;
          acc_d   = CoefC5;
          step_d  = '0;
          state_d = SMulLo;
        end
      end
      SMulLo: begin
        // Low chunk of the accumulator times speed, plus the rounding half.
        mac_req.op_a   = $signed({{(MulAW - ChunkW){1'b0}}, acc_q[ChunkW-1:0]});
        mac_req.op_b   = $signed({1'b0, x_q});
        mac_req.addend = HornerRound;
        state_d        = SMulHi;
      end
      SMulHi: begin
        // High chunk, shifted into place, added to the low partial product.
        mac_req.op_a     = MulAW'($signed(acc_q[AccW-1:ChunkW]));
        mac_req.op_b     = $signed({1'b0, x_q});
        mac_req.addend   = mac_res;
        mac_req.shift_hi = 1'b1;
        state_d          = SAccum;
      end
      SAccum: begin
        acc_d  = AccW'(mac_res >>> HornerShift) + coef_lower(step_q);
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = SPoly;
        end else begin
          state_d = SMulLo;
        end
      end
      SPoly: begin
        // Offset is a whole multiple of the rounding step, so it folds in here.
        s_d     = MulAW'(poly_sum >>> PolyShift);
        state_d = SGain;
      end
      SGain: begin
        mac_req.op_a   = s_q;
        mac_req.op_b   = $signed({1'b0, cfg_i.gain});
        mac_req.addend = GainRound;
        state_d        = SRange;
      end
      SRange: begin
        // Rules in priority order; only in-range values go on to smoothing.
        if (raw <= $signed(RawW'(cfg_i.min_duty))) begin
          duty_d   = '0;
          status_d = StatBelowMin;
          state_d  = SDone;
        end else if (raw > $signed(RawW'(cfg_i.warn_duty))) begin
          duty_d   = '0;
          status_d = StatWarnOff;
          state_d  = SDone;
        end else if (raw > $signed(RawW'(cfg_i.max_duty))) begin
          duty_d   = cfg_i.max_duty;
          status_d = StatClamp;
          state_d  = SDone;
        end else begin
          rawlo_d = raw[DutyW-1:0];
          state_d = SBlend;
        end
      end
      SBlend: begin
        // last * 2^16 + w * (raw - last) + half equals the two-weight blend.
        mac_req.op_a   = $signed(MulAW'(weight));
        mac_req.op_b   = $signed({1'b0, rawlo_q}) - $signed({1'b0, last_q});
        mac_req.addend = $signed(ProdW'({last_q, 16'h8000}));
        state_d        = SBlendSum;
      end
      SBlendSum: begin
        if (mac_res[ProdW-1:2*DutyW] != '0) begin
          duty_d = '1;
        end else begin
          duty_d = mac_res[2*DutyW-1:DutyW];
        end
        status_d = StatSmooth;
        state_d  = SDone;
      end
      SDone: begin
        if (res_ready_i) begin
          last_d  = duty_q;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state and the last delivered duty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q  <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

  // Working registers, payload only.
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    acc_q    <= acc_d;
    s_q      <= s_d;
    rawlo_q  <= rawlo_d;
    duty_q   <= duty_d;
    status_q <= status_d;
  end

  assign in_ready_o    = (state_q == SIdle);
  assign res_valid_o   = (state_q == SDone);
  assign res_o.duty    = duty_q;
  assign res_o.status  = status_q;

  `include "assist_duty_curve_top_assert.svh"

  `ADC_ASSERT_NEXT(a_done_returns_idle, res_valid_o && res_ready_i, in_ready_o, "core did not return to idle after a result transfer")
  `ADC_ASSERT_NEXT(a_last_tracks_result, res_valid_o && res_ready_i, last_q == $past(res_o.duty), "last duty does not match the delivered result")
  `ADC_ASSERT_NOW(a_step_bounded, 1'b1, step_q <= StepEnd, "Horner step counter out of range")
  `ADC_ASSERT_NOW(a_smooth_in_range, state_q == SBlend, rawlo_q != '0, "zero raw duty reached smoothing")

endmodule

// ===== hw/rtl/assist_duty_curve_top.sv =====
// Assist duty curve block, top level.
//
// Slave stream: s_axis_tdata[15:0] is the wheel speed in km/h, unsigned Q8.8.
// Master stream: m_axis_tdata[15:0] is the duty, unsigned Q8.8, and
// m_axis_tdata[17:16] the status (0 smoothed, 1 below minimum, 2 clamped,
// 3 over warning); upper bits are zero. Every input transfer gives exactly
// one output transfer, in order.
// Configuration: a write with cfg_we_i high stores cfg_wdata_i into register
// cfg_addr_i (0 gain, 1 offset, 2 min, 3 max, 4 warn, 5 smooth up,
// 6 smooth down); other indexes are ignored. Write only while idle.
// An input transfer starts the Horner steps, offset fold, gain pass and range
// rules; only smoothed results add the blend pass. A new speed is taken only
// once the previous result has left the core. The single shared multiplier
// sets the steps: two passes for each of the five Horner steps plus an accumulate step.
// Reset restores the register defaults and clears the previous duty to zero.
// A stalled master side holds the result in the output register; the next
// item is still taken and worked on, and waits in the core until it drains.
module assist_duty_curve_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Speed input: [15:0] speed_kmh
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,
  // Result output: [15:0] duty, [17:16] duty_status, [23:18] zero
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [adc_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [15:0]                       cfg_wdata_i
);
  import adc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  result_t core_res;
  logic    core_valid;
  logic    core_ready;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegGain:       cfg_d.gain        = cfg_wdata_i;
        RegOffset:     cfg_d.offset      = $signed(cfg_wdata_i);
        RegMinDuty:    cfg_d.min_duty    = cfg_wdata_i;
        RegMaxDuty:    cfg_d.max_duty    = cfg_wdata_i;
        RegWarnDuty:   cfg_d.warn_duty   = cfg_wdata_i;
        RegSmoothUp:   cfg_d.smooth_up   = cfg_wdata_i;
        RegSmoothDown: cfg_d.smooth_down = cfg_wdata_i;
        default:       cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain        <= 16'd4096;
      cfg_q.offset      <= '0;
      cfg_q.min_duty    <= '0;
      cfg_q.max_duty    <= '1;
      cfg_q.warn_duty   <= '1;
      cfg_q.smooth_up   <= '1;
      cfg_q.smooth_down <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  adc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_speed_i  (s_axis_tdata),
    .res_valid_o (core_valid),
    .res_ready_i (core_ready),
    .res_o       (core_res)
  );

  // Output register: loads a result when empty or draining this cycle.
  assign core_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (core_valid && core_ready) begin
      out_d       = core_res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_q.status, out_q.duty};

endmodule
